/* hw/rtl/mm3_pkg.sv */
// Shared types and constants for the MurmurHash3 x86_32 stream hasher.
package mm3_pkg;

  localparam logic [31:0] MH_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MH_C2  = 32'h1b873593;
  localparam logic [31:0] MH_ADD = 32'he6546b64;
  localparam logic [31:0] MH_F1  = 32'h85ebca6b;
  localparam logic [31:0] MH_F2  = 32'hc2b2ae35;

  localparam logic [1:0] REQ_APPEND  = 2'd0;
  localparam logic [1:0] REQ_QUERY   = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_APPEND_SHORT,
    OP_LOAD_BLOCK,
    OP_LOAD_TAIL,
    OP_RESTART,
    OP_MUL_C1,
    OP_MUL_C2,
    OP_MIX,
    OP_FOLD,
    OP_MUL_F1,
    OP_MUL_F2,
    OP_EMIT
  } mm3_op_t;

  typedef struct packed {
    mm3_op_t op;
  } mm3_cmd_t;

  typedef struct packed {
    logic tail_full;
  } mm3_stat_t;

endpackage

/* hw/rtl/mm3_if.sv */
// Valid/ready channel interfaces for requests, digests and seed writes.
interface mm3_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

interface mm3_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest;
  modport source (output valid, output digest, input ready);
  modport sink (input valid, input digest, output ready);
endinterface

interface mm3_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] seed;
  modport source (output valid, output seed, input ready);
  modport sink (input valid, input seed, output ready);
endinterface

/* hw/rtl/mm3_dpath.sv */
// Datapath of the hasher: hash state, shared multiplier and digest register.
module mm3_dpath
  import mm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  mm3_cmd_t    cmd,
  input  logic [7:0]  data_byte,
  input  logic        cfg_we,
  input  logic [31:0] cfg_seed,
  output logic [31:0] digest,
  output mm3_stat_t   stat
);

  logic [31:0] seed_r;
  logic [31:0] hash_r, hash_nxt;
  logic [23:0] tail_r, tail_nxt;
  logic [1:0]  count_r, count_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] digest_r, digest_nxt;

  logic [31:0] mul_a, mul_k, prod;
  logic [31:0] mix_x, mix_r, fold_x;

  always_comb begin
    case (cmd.op)
      OP_MUL_C1: begin
        mul_a = acc_r;
        mul_k = MH_C1;
      end
      OP_MUL_C2: begin
        mul_a = {acc_r[16:0], acc_r[31:17]};
        mul_k = MH_C2;
      end
      OP_MUL_F1: begin
        mul_a = acc_r;
        mul_k = MH_F1;
      end
      OP_MUL_F2: begin
        mul_a = acc_r ^ (acc_r >> 13);
        mul_k = MH_F2;
      end
      default: begin
        mul_a = acc_r;
        mul_k = 32'd0;
      end
    endcase
  end

  assign prod   = mul_a * mul_k;
  assign mix_x  = hash_r ^ acc_r;
  assign mix_r  = {mix_x[18:0], mix_x[31:19]};
  assign fold_x = hash_r ^ acc_r ^ total_r;

  always_comb begin
    hash_nxt   = hash_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    total_nxt  = total_r;
    acc_nxt    = acc_r;
    digest_nxt = digest_r;
    case (cmd.op)
      OP_APPEND_SHORT: begin
        case (count_r)
          2'd0:    tail_nxt[7:0]   = data_byte;
          2'd1:    tail_nxt[15:8]  = data_byte;
          default: tail_nxt[23:16] = data_byte;
        endcase
        count_nxt = count_r + 2'd1;
        total_nxt = total_r + 32'd1;
      end
      OP_LOAD_BLOCK: begin
        acc_nxt   = {data_byte, tail_r};
        tail_nxt  = 24'd0;
        count_nxt = 2'd0;
        total_nxt = total_r + 32'd1;
      end
      OP_LOAD_TAIL: acc_nxt = {8'd0, tail_r};
      OP_RESTART: begin
        hash_nxt  = seed_r;
        tail_nxt  = 24'd0;
        count_nxt = 2'd0;
        total_nxt = 32'd0;
      end
      OP_MUL_C1, OP_MUL_C2, OP_MUL_F1, OP_MUL_F2: acc_nxt = prod;
      OP_MIX:  hash_nxt = (mix_r << 2) + mix_r + MH_ADD;
      OP_FOLD: acc_nxt = fold_x ^ (fold_x >> 16);
      OP_EMIT: digest_nxt = acc_r ^ (acc_r >> 16);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= 32'd0;
      hash_r  <= 32'd0;
      tail_r  <= 24'd0;
      count_r <= 2'd0;
      total_r <= 32'd0;
    end else begin
      if (cfg_we) begin
        seed_r <= cfg_seed;
      end
      hash_r  <= hash_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    digest_r <= digest_nxt;
  end

  assign digest         = digest_r;
  assign stat.tail_full = (count_r == 2'd3);

endmodule

/* hw/rtl/mm3_ctrl.sv */
// Controller state machine that sequences block mixing and digest finalization.
module mm3_ctrl
  import mm3_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_req_type,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  mm3_stat_t  stat,
  output mm3_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_C1,
    S_MUL_C2,
    S_MIX,
    S_FOLD,
    S_MUL_F1,
    S_MUL_F2,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   query_r, query_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    query_nxt     = query_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_req_type)
            REQ_APPEND: begin
              if (stat.tail_full) begin
                cmd.op    = OP_LOAD_BLOCK;
                query_nxt = 1'b0;
                state_nxt = S_MUL_C1;
              end else begin
                cmd.op = OP_APPEND_SHORT;
              end
            end
            REQ_QUERY: begin
              cmd.op    = OP_LOAD_TAIL;
              query_nxt = 1'b1;
              state_nxt = S_MUL_C1;
            end
            REQ_RESTART: cmd.op = OP_RESTART;
            default: ;
          endcase
        end
      end
      S_MUL_C1: begin
        cmd.op    = OP_MUL_C1;
        state_nxt = S_MUL_C2;
      end
      S_MUL_C2: begin
        cmd.op    = OP_MUL_C2;
        state_nxt = query_r ? S_FOLD : S_MIX;
      end
      S_MIX: begin
        cmd.op    = OP_MIX;
        state_nxt = S_IDLE;
      end
      S_FOLD: begin
        cmd.op    = OP_FOLD;
        state_nxt = S_MUL_F1;
      end
      S_MUL_F1: begin
        cmd.op    = OP_MUL_F1;
        state_nxt = S_MUL_F2;
      end
      S_MUL_F2: begin
        cmd.op    = OP_MUL_F2;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      query_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      query_r     <= query_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_req_type == REQ_QUERY) |=> (state_r == S_MUL_C1) && query_r)
    else $error("Accepted query did not start the scramble sequence.");

  a_block_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_req_type == REQ_APPEND) && stat.tail_full
      |=> (state_r == S_MUL_C1) && !query_r)
    else $error("Full-block append did not start the mixing sequence.");

  a_mix_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MIX) |=> (state_r == S_IDLE))
    else $error("Hash update did not return to idle.");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) && (!out_valid_r || out_ready) |=> out_valid_r)
    else $error("Digest emission did not raise the output valid.");
`endif

endmodule

/* hw/rtl/murmur3_32_stream_hasher.sv */
// Top level of the MurmurHash3 x86_32 stream hasher.
// An append of the first three bytes of a block, or a restart, is done on acceptance;
// an append that completes a block then runs MUL_C1, MUL_C2 (shared multiplier) and MIX.
// Query, 7 steps: load, MUL_C1, MUL_C2, FOLD, MUL_F1, MUL_F2, EMIT raising digest valid.
// No new item is taken before the last is through; a query is held while a digest waits.
// Synchronous active-low reset clears the hash, tail, count and seed to zero.
module murmur3_32_stream_hasher
  import mm3_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  mm3_req_if.sink   in_ch,
  mm3_dig_if.source out_ch,
  mm3_cfg_if.sink   cfg_ch
);

  mm3_cmd_t  cmd;
  mm3_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  mm3_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  mm3_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .data_byte (in_ch.data_byte),
    .cfg_we    (cfg_ch.valid),
    .cfg_seed  (cfg_ch.seed),
    .digest    (out_ch.digest),
    .stat      (stat)
  );

endmodule

/* verif/tb_murmur3_32_stream_hasher.sv */
// Self-checking testbench for the MurmurHash3 x86_32 stream hasher.
`timescale 1ns / 100ps

module tb_murmur3_32_stream_hasher;
  import mm3_pkg::*;

  localparam logic [1:0] REQ_RSVD = 2'd3;
  localparam int CLK_HALF = 6;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 16;

  logic clk;
  logic rst_n;

  mm3_req_if in_if();
  mm3_dig_if out_if();
  mm3_cfg_if cfg_if();

  murmur3_32_stream_hasher u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  logic [31:0] seed_reg;
  logic [31:0] run_hash;
  logic [23:0] tail_bytes;
  logic [1:0]  tail_cnt;
  logic [31:0] byte_total;
  logic [31:0] pending_digests[$];
  logic [31:0] want_digest;

  int  fail_count;
  int  cycle_cnt;
  int  sent_items;
  bit  idle_in;
  bit  idle_out;
  int  out_park;

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] scramble_block(input logic [31:0] k);
    k = k * MH_C1;
    k = {k[16:0], k[31:17]};
    k = k * MH_C2;
    return k;
  endfunction

  function automatic logic [31:0] finalize_digest();
    logic [31:0] h;
    h = run_hash;
    if (tail_cnt != 2'd0) h = h ^ scramble_block({8'h00, tail_bytes});
    h = h ^ byte_total;
    h = h ^ (h >> 16);
    h = h * MH_F1;
    h = h ^ (h >> 13);
    h = h * MH_F2;
    h = h ^ (h >> 16);
    return h;
  endfunction

  task automatic apply_request(input logic [1:0] rt, input logic [7:0] b);
    logic [31:0] blk;
    case (rt)
      REQ_APPEND: begin
        blk = {8'h00, tail_bytes} | ({24'h0, b} << (8 * tail_cnt));
        byte_total = byte_total + 32'd1;
        if (tail_cnt == 2'd3) begin
          run_hash = run_hash ^ scramble_block(blk);
          run_hash = {run_hash[18:0], run_hash[31:19]};
          run_hash = run_hash * 32'd5 + MH_ADD;
          tail_bytes = '0;
          tail_cnt = 2'd0;
        end else begin
          tail_bytes = blk[23:0];
          tail_cnt = tail_cnt + 2'd1;
        end
      end
      REQ_QUERY: pending_digests.push_back(finalize_digest());
      REQ_RESTART: begin
        run_hash = seed_reg;
        tail_bytes = '0;
        tail_cnt = 2'd0;
        byte_total = '0;
      end
      default: ;
    endcase
  endtask

  task automatic send_req(input logic [1:0] rt, input logic [7:0] b);
    int gap;
    gap = idle_in ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.req_type <= rt;
    in_if.data_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    apply_request(rt, b);
    sent_items++;
  endtask

  task automatic settle_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_digests.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_seed(input logic [31:0] val);
    settle_idle();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.seed <= val;
    do @(posedge clk); while (!cfg_if.ready);
    seed_reg = val;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // With idle_out, the receiver draws a stall per transaction; a park overrides it.
  initial begin
    int hold;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      hold = idle_out ? $urandom_range(0, 5) : 0;
      if (out_park > 0) begin
        hold = out_park;
        out_park = 0;
      end
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_digests.size() == 0) begin
        $error("digest: expected none, actual %08h", out_if.digest);
        fail_count++;
      end else begin
        want_digest = pending_digests.pop_front();
        if (out_if.digest !== want_digest) begin
          $error("digest: expected %08h, actual %08h", want_digest, out_if.digest);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_req(REQ_RESTART, 8'h00);
    send_req(REQ_QUERY, 8'hFF);
    send_req(REQ_APPEND, 8'h00);
    send_req(REQ_QUERY, 8'h00);
    send_req(REQ_APPEND, 8'hFF);
    send_req(REQ_QUERY, 8'h00);
    send_req(REQ_APPEND, 8'h80);
    send_req(REQ_QUERY, 8'h00);
    send_req(REQ_APPEND, 8'h01);
    send_req(REQ_QUERY, 8'h00);
    send_req(REQ_QUERY, 8'h00);
    send_req(REQ_RSVD, 8'hFF);
    send_req(REQ_QUERY, 8'h00);
    send_req(REQ_APPEND, 8'h7F);
    send_req(REQ_APPEND, 8'hFE);
    send_req(REQ_APPEND, 8'h55);
    send_req(REQ_APPEND, 8'hAA);
    send_req(REQ_QUERY, 8'h00);
    send_req(REQ_RESTART, 8'hFF);
    send_req(REQ_QUERY, 8'h00);
  endtask

  task automatic test_seed_extremes();
    write_seed(32'hFFFF_FFFF);
    send_req(REQ_QUERY, 8'h00);
    send_req(REQ_RESTART, 8'h00);
    send_req(REQ_QUERY, 8'h00);
    send_req(REQ_APPEND, 8'hFF);
    send_req(REQ_APPEND, 8'hFF);
    send_req(REQ_APPEND, 8'hFF);
    send_req(REQ_QUERY, 8'h00);
    write_seed(32'h0000_0000);
    send_req(REQ_RESTART, 8'h00);
    send_req(REQ_QUERY, 8'h00);
    write_seed(32'h8000_0001);
    send_req(REQ_APPEND, 8'h12);
    send_req(REQ_RESTART, 8'h00);
    send_req(REQ_APPEND, 8'h34);
    send_req(REQ_QUERY, 8'h00);
  endtask

  task automatic test_random_streams(input int phases, input int per_phase);
    int start;
    int r;
    for (int p = 0; p < phases; p++) begin
      case (p % 4)
        0: write_seed($urandom());
        1: write_seed(32'hFFFF_FFFF);
        2: write_seed(32'h0000_0000);
        default: write_seed($urandom());
      endcase
      idle_in = (p % 3) != 1;
      idle_out = (p % 3) != 2;
      send_req(REQ_RESTART, 8'($urandom_range(0, 255)));
      start = sent_items;
      while (sent_items - start < per_phase) begin
        r = $urandom_range(0, 99);
        if (r < 3) send_req(REQ_RESTART, 8'($urandom_range(0, 255)));
        else if (r < 6) send_req(REQ_RSVD, 8'($urandom_range(0, 255)));
        else if (r < 22) send_req(REQ_QUERY, 8'($urandom_range(0, 255)));
        else send_req(REQ_APPEND, 8'($urandom_range(0, 255)));
      end
    end
    idle_in = 1'b1;
    idle_out = 1'b1;
  endtask

  task automatic test_output_backpressure();
    settle_idle();
    idle_in = 1'b0;
    idle_out = 1'b0;
    out_park = 200;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 0) send_req(REQ_APPEND, 8'($urandom_range(0, 255)));
      else send_req(REQ_QUERY, 8'h00);
    end
    idle_in = 1'b1;
    idle_out = 1'b1;
  endtask

  initial begin
    int waited;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.req_type = REQ_APPEND;
    in_if.data_byte = 8'h00;
    cfg_if.valid = 1'b0;
    cfg_if.seed = 32'h0;
    seed_reg = '0;
    run_hash = '0;
    tail_bytes = '0;
    tail_cnt = 2'd0;
    byte_total = '0;
    fail_count = 0;
    cycle_cnt = 0;
    sent_items = 0;
    idle_in = 1'b1;
    idle_out = 1'b1;
    out_park = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_seed_extremes();
    test_output_backpressure();
    test_random_streams(5, 220);

    @(negedge clk);
    in_if.valid <= 1'b0;
    waited = 0;
    while (pending_digests.size() != 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    if (pending_digests.size() != 0) begin
      $error("digest: %0d expected transactions never arrived", pending_digests.size());
      fail_count++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
